/* src/mfse_pkg.sv */
package mfse_pkg;

  localparam int MAX_WINDOW    = 15;
  localparam int HISTORY_DEPTH = 16;
  localparam int SAMPLE_BITS   = 16;
  localparam int INDEX_BITS    = 16;
  localparam int RESULT_CAP    = 8;

  localparam int WL_BITS  = 4;
  localparam logic [WL_BITS-1:0] WL_RESET = 4'd5;

  localparam int HALF_MAX   = MAX_WINDOW / 2;
  localparam int HALF_BITS  = $clog2(HALF_MAX + 1);
  localparam int SORT_SLOTS = MAX_WINDOW;
  localparam int SLOT_BITS  = $clog2(SORT_SLOTS);
  localparam int CNT_BITS   = $clog2(SORT_SLOTS + 1);
  localparam int HIST_AW    = $clog2(HISTORY_DEPTH);
  localparam int RES_BITS   = $clog2(RESULT_CAP + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_READ,
    S_WAIT,
    S_EMIT,
    S_ERR
  } mfse_state_e;

  typedef struct packed {
    logic clear;
    logic insert;
  } sort_ctrl_t;

endpackage

/* src/median_filter_shrinking_edges_unit.sv */
// channel  direction  handshake                    payload
// in       input      in_valid_i / in_ready_o      sample_i, end_of_frame_i
// out      output     out_valid_o / out_ready_i    median_value_o, position_o,
//                                                  last_of_run_o, window_error_o
// config   input      window_length_we_i           window_length_i
//
// each median is planned, then its 2*h+1 history entries are read (one
// port, one entry a cycle, each inserted into the sorter the cycle after its
// read), then the sorter settles and the output register is loaded; an item
// is accepted while idle, and planning returns to idle when it has no results.
// an even window loads its error result in the error state once the output is free.
// reset clears counters and control; history holds no reset value.
// a stalled output holds the next result back; the last result of an item
// waits in the output register while the next item is accepted.
module median_filter_shrinking_edges_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    window_length_we_i,
  input  logic [mfse_pkg::WL_BITS-1:0]            window_length_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [mfse_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                    end_of_frame_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [mfse_pkg::SAMPLE_BITS-1:0] median_value_o,
  output logic [mfse_pkg::INDEX_BITS-1:0]         position_o,
  output logic                                    last_of_run_o,
  output logic                                    window_error_o
);
  import mfse_pkg::*;

  mfse_state_e state_q, state_d;

  logic [WL_BITS-1:0]    win_len_q;
  logic [INDEX_BITS-1:0] cnt_q, emit_q, n_q, c_q;
  logic                  eof_q, last_q, rd_valid_q;
  logic [RES_BITS-1:0]   r_q;
  logic [HALF_BITS-1:0]  h_q;
  logic [SLOT_BITS-1:0]  j_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] med_q;
  logic [INDEX_BITS-1:0]         pos_q;
  logic                          lor_q, err_q;

  logic                  accept, even_win, slot_free;
  logic                  ram_re, load_med, load_err, finish, plan_go;
  sort_ctrl_t            sort_ctrl;
  logic [WL_BITS-1:0]    half_raw;
  logic [HALF_BITS-1:0]  hmax, h_new;
  logic [INDEX_BITS-1:0] hmax_ext, pending, nxt_pend, right_gap, min_c, min_ce;
  logic                  stop_now, stop_next;
  logic [INDEX_BITS-1:0] rd_pos;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] median;
  logic [CNT_BITS-1:0]   sort_count;

  assign accept    = in_valid_i && in_ready_o;
  assign even_win  = !win_len_q[0];
  assign slot_free = !out_valid_q || out_ready_i;

  // half-width, capped at the widest window
  assign half_raw = win_len_q >> 1;
  assign hmax     = (half_raw > WL_BITS'(HALF_MAX)) ? HALF_BITS'(HALF_MAX)
                                                    : HALF_BITS'(half_raw);
  assign hmax_ext = INDEX_BITS'(hmax);

  // planning of the next position of the run
  assign pending  = n_q + INDEX_BITS'(1) - emit_q;
  assign nxt_pend = pending - INDEX_BITS'(1);
  assign stop_now = (r_q == RES_BITS'(RESULT_CAP)) || (pending == '0) ||
                    (!eof_q && pending < hmax_ext + INDEX_BITS'(1));
  assign stop_next = (r_q + RES_BITS'(1) == RES_BITS'(RESULT_CAP)) ||
                     (nxt_pend == '0) ||
                     (!eof_q && nxt_pend < hmax_ext + INDEX_BITS'(1));

  // window shrinks at the left edge, and at the right edge on frame end
  assign right_gap = n_q - emit_q;
  assign min_c     = (emit_q < hmax_ext) ? emit_q : hmax_ext;
  assign min_ce    = (right_gap < min_c) ? right_gap : min_c;
  assign h_new     = eof_q ? HALF_BITS'(min_ce) : HALF_BITS'(min_c);

  assign rd_pos = c_q - INDEX_BITS'(h_q) + INDEX_BITS'(j_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = even_win ? S_ERR : S_PLAN;
        end
      end
      S_PLAN: begin
        state_d = stop_now ? S_IDLE : S_READ;
      end
      S_READ: begin
        if (j_q == SLOT_BITS'({h_q, 1'b0})) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          state_d = last_q ? S_IDLE : S_PLAN;
        end
      end
      S_ERR: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    ram_re           = 1'b0;
    sort_ctrl.clear  = 1'b0;
    sort_ctrl.insert = rd_valid_q;
    load_med         = 1'b0;
    load_err         = 1'b0;
    finish           = 1'b0;
    plan_go          = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_PLAN: begin
        sort_ctrl.clear = 1'b1;
        plan_go         = !stop_now;
        finish          = stop_now;
      end
      S_READ: begin
        ram_re = 1'b1;
      end
      S_EMIT: begin
        load_med = slot_free;
        finish   = slot_free && last_q;
      end
      S_ERR: begin
        load_err = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_len_q   <= WL_RESET;
      cnt_q       <= '0;
      emit_q      <= '0;
      r_q         <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= ram_re;
      if (window_length_we_i) begin
        win_len_q <= window_length_i;
      end
      if (accept) begin
        r_q <= '0;
        if (even_win && end_of_frame_i) begin
          cnt_q  <= '0;
          emit_q <= '0;
        end else begin
          cnt_q <= cnt_q + INDEX_BITS'(1);
        end
      end
      if (load_med) begin
        emit_q <= emit_q + INDEX_BITS'(1);
        r_q    <= r_q + RES_BITS'(1);
      end
      // frame end drops the counters once the run is out
      if (finish && eof_q) begin
        cnt_q  <= '0;
        emit_q <= '0;
      end
      if (load_med || load_err) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      n_q   <= cnt_q;
      eof_q <= end_of_frame_i;
    end
    if (plan_go) begin
      c_q    <= emit_q;
      h_q    <= h_new;
      last_q <= stop_next;
      j_q    <= '0;
    end else if (ram_re) begin
      j_q <= j_q + SLOT_BITS'(1);
    end
    if (load_med) begin
      med_q <= median;
      pos_q <= c_q;
      lor_q <= last_q;
      err_q <= 1'b0;
    end else if (load_err) begin
      med_q <= '0;
      pos_q <= n_q;
      lor_q <= 1'b1;
      err_q <= 1'b1;
    end
  end

  mfse_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (cnt_q[HIST_AW-1:0]),
    .wdata_i (sample_i),
    .re_i    (ram_re),
    .raddr_i (rd_pos[HIST_AW-1:0]),
    .rdata_o (rd_data)
  );

  mfse_sorter u_sorter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (sort_ctrl),
    .data_i   (rd_data),
    .half_i   (h_q),
    .median_o (median),
    .count_o  (sort_count)
  );

  assign out_valid_o    = out_valid_q;
  assign median_value_o = med_q;
  assign position_o     = pos_q;
  assign last_of_run_o  = lor_q;
  assign window_error_o = err_q;

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_error_o |-> median_value_o == '0 && last_of_run_o)
    else $error("error result malformed");

  a_result_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_q <= RES_BITS'(RESULT_CAP)) else $error("too many results for one item");

  a_window_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> sort_count == CNT_BITS'({h_q, 1'b0}) + CNT_BITS'(1))
    else $error("median taken from incomplete window");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o) else $error("second transaction taken while busy");

endmodule

/* src/mfse_ram.sv */
module mfse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/mfse_sorter.sv */
module mfse_sorter (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  mfse_pkg::sort_ctrl_t                    ctrl_i,
  input  logic signed [mfse_pkg::SAMPLE_BITS-1:0] data_i,
  input  logic [mfse_pkg::HALF_BITS-1:0]          half_i,
  output logic signed [mfse_pkg::SAMPLE_BITS-1:0] median_o,
  output logic [mfse_pkg::CNT_BITS-1:0]           count_o
);
  import mfse_pkg::*;

  logic signed [SAMPLE_BITS-1:0] slot_q [SORT_SLOTS];
  logic signed [SAMPLE_BITS-1:0] slot_d [SORT_SLOTS];
  logic [SORT_SLOTS-1:0]         gt;
  logic [CNT_BITS-1:0]           cnt_q, cnt_d;
  logic                          sorted_ok;

  // every filled slot compares against the new entry at once
  always_comb begin
    for (int m = 0; m < SORT_SLOTS; m++) begin
      gt[m] = (CNT_BITS'(m) < cnt_q) && (slot_q[m] > data_i);
    end
  end

  // larger entries shift up one slot, the new one drops into the gap
  always_comb begin
    if (gt[0] || cnt_q == '0) begin
      slot_d[0] = data_i;
    end else begin
      slot_d[0] = slot_q[0];
    end
    for (int m = 1; m < SORT_SLOTS; m++) begin
      if (gt[m-1]) begin
        slot_d[m] = slot_q[m-1];
      end else if (gt[m] || CNT_BITS'(m) == cnt_q) begin
        slot_d[m] = data_i;
      end else begin
        slot_d[m] = slot_q[m];
      end
    end
  end

  always_comb begin
    if (ctrl_i.clear) begin
      cnt_d = '0;
    end else if (ctrl_i.insert) begin
      cnt_d = cnt_q + CNT_BITS'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert) begin
      slot_q <= slot_d;
    end
  end

  assign median_o = slot_q[SLOT_BITS'(half_i)];
  assign count_o  = cnt_q;

  always_comb begin
    sorted_ok = 1'b1;
    for (int m = 0; m < SORT_SLOTS - 1; m++) begin
      if (CNT_BITS'(m + 1) < cnt_q && slot_q[m] > slot_q[m+1]) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sorted_ok) else $error("sorter slots out of order");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(SORT_SLOTS)) else $error("sorter overfilled");

  a_clear_vs_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.clear && ctrl_i.insert)) else $error("clear during insert");

endmodule
